>>> sv/nsfp_pkg.sv
// Shared types, constants and decode functions for the NMEA sentence field parser.
`default_nettype none

package nsfp_pkg;

  localparam int FIELD_CHARS_DEF = 16;
  localparam int NUM_SLOTS       = 15;

  localparam logic [3:0] NO_SLOT   = 4'd15;
  localparam logic [3:0] VIEW_SLOT = 4'd14;

  localparam logic [4:0] NO_FIELD   = 5'd31;
  localparam logic [4:0] LAST_FIELD = 5'd30;

  // header_count value once talker and four header letters are consumed
  localparam logic [2:0] HDR_BODY = 3'd5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // header letters packed first letter in the low byte
  localparam logic [31:0] HDR_PRMC = 32'h434D5250;
  localparam logic [31:0] HDR_NRMC = 32'h434D524E;
  localparam logic [31:0] HDR_PGGA = 32'h41474750;
  localparam logic [31:0] HDR_NGGA = 32'h4147474E;
  localparam logic [31:0] HDR_PVTG = 32'h47545650;
  localparam logic [31:0] HDR_NVTG = 32'h4754564E;
  localparam logic [31:0] HDR_PGSV = 32'h56534750;
  localparam logic [31:0] HDR_LGSV = 32'h5653474C;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_RMC   = 3'd1,
    KIND_GGA   = 3'd2,
    KIND_GPVTG = 3'd3,
    KIND_GNVTG = 3'd4,
    KIND_GPGSV = 3'd5,
    KIND_GLGSV = 3'd6
  } kind_t;

  typedef struct packed {
    logic [2:0] sentence_event;
    logic [7:0] read_char;
    logic [3:0] read_length;
    logic [7:0] gps_sats;
    logic [7:0] glonass_sats;
  } result_t;

  typedef struct packed {
    logic full;
    logic pop;
  } buf_status_t;

  function automatic kind_t classify(input logic [31:0] w);
    kind_t k;
    case (w)
      HDR_PRMC, HDR_NRMC: k = KIND_RMC;
      HDR_PGGA, HDR_NGGA: k = KIND_GGA;
      HDR_PVTG:           k = KIND_GPVTG;
      HDR_NVTG:           k = KIND_GNVTG;
      HDR_PGSV:           k = KIND_GPGSV;
      HDR_LGSV:           k = KIND_GLGSV;
      default:            k = KIND_NONE;
    endcase
    return k;
  endfunction

  // slot a field of a sentence lands in, NO_SLOT when dropped
  function automatic logic [3:0] slot_of(input kind_t kind, input logic [4:0] field);
    logic [3:0] s;
    s = NO_SLOT;
    case (kind)
      KIND_RMC: begin
        if (field <= 5'd8) s = field[3:0];
      end
      KIND_GGA: begin
        if (field == 5'd6) s = 4'd9;
        else if (field == 5'd8) s = 4'd10;
      end
      KIND_GPVTG, KIND_GNVTG: begin
        if (field == 5'd0) s = 4'd11;
        else if (field == 5'd1) s = 4'd12;
        else if (field == 5'd4) s = 4'd13;
      end
      KIND_GPGSV, KIND_GLGSV: begin
        if (field == 5'd2) s = VIEW_SLOT;
      end
      default: s = NO_SLOT;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> sv/nsfp_skid.sv
// Two-entry result buffer between the memory read stage and the result port.
`default_nettype none

module nsfp_skid (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  nsfp_pkg::result_t     push_data,
  output nsfp_pkg::buf_status_t status,
  output logic                  out_valid,
  input  wire                   out_stall,
  output nsfp_pkg::result_t     out_data
);

  nsfp_pkg::result_t ent_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid   = (cnt_r != 2'd0);
  assign out_data    = ent_r[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  assign status.full = (cnt_r == 2'd2);
  assign status.pop  = pop;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/nmea_sentence_field_parser.sv
// NMEA sentence field parser: byte decoder, field store memory and result buffer.
// An accepted beat reads field_store into mem_q_r and waits in the read stage, then goes
// to the result buffer, which offers it on the result port. Throughput: one beat per
// cycle while in_stall is low; field_store is single ported, one write or read a beat.
// Reset (rst_n low, synchronous) idles the decoder and clears slot lengths and counts;
// field_store needs no clearing pass, a character is only returned below its slot length.
`default_nettype none

module nmea_sentence_field_parser #(
  parameter int FIELD_CHARS = nsfp_pkg::FIELD_CHARS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  // input channel
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_opcode,
  input  wire  [7:0] in_rx_byte,
  input  wire  [3:0] in_read_slot,
  input  wire  [3:0] in_read_pos,
  // result channel
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] out_sentence_event,
  output logic [7:0] out_read_char,
  output logic [3:0] out_read_length,
  output logic [7:0] out_gps_sats_in_view,
  output logic [7:0] out_glonass_sats_in_view
);

  // characters kept per field: one short of the slot, and never above what 4 bits count
  localparam int MAX_STORED = (FIELD_CHARS - 1) < 15 ? (FIELD_CHARS - 1) : 15;
  localparam int DEPTH      = nsfp_pkg::NUM_SLOTS * FIELD_CHARS;
  localparam int AW         = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------------
  logic              line_active_r, line_active_nxt;
  logic [2:0]        hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0]       hdr_r, hdr_nxt;            // first three header letters
  nsfp_pkg::kind_t   kind_r, kind_nxt;
  logic [4:0]        field_idx_r, field_idx_nxt;
  logic [3:0]        char_pos_r, char_pos_nxt;
  logic [3:0]        len_r   [nsfp_pkg::NUM_SLOTS];
  logic [3:0]        len_nxt [nsfp_pkg::NUM_SLOTS];
  logic [7:0]        view_acc_r, view_acc_nxt;
  logic              digits_run_r, digits_run_nxt;
  logic [7:0]        gps_r, gps_nxt;
  logic [7:0]        glo_r, glo_nxt;

  // field_store: single port, registered read data
  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [3:0]        mem_slot;
  logic [3:0]        mem_pos;

  // read stage: one beat waiting on the memory read data
  logic              s1_valid_r, s1_valid_nxt;
  logic [2:0]        s1_event_r;
  logic [3:0]        s1_len_r;
  logic              s1_char_ok_r;
  logic [7:0]        s1_gps_r;
  logic [7:0]        s1_glo_r;

  logic              accept;
  logic              is_read;
  logic [7:0]        b;
  logic [4:0]        idx_comma;
  logic [3:0]        slot_cur;
  logic [3:0]        slot_comma;
  logic              is_digit;
  logic [3:0]        digit;
  logic [11:0]       acc_prod;
  logic [2:0]        event_val;
  logic [3:0]        rd_len;
  logic              rd_char_ok;

  nsfp_pkg::buf_status_t buf_st;
  nsfp_pkg::result_t     push_data;
  nsfp_pkg::result_t     out_data;
  logic                  push;

  // Stall only when the read stage and both buffer entries are taken; no
  // combinational path from out_stall.
  assign in_stall = s1_valid_r && buf_st.full;
  assign accept   = in_valid && !in_stall;
  assign is_read  = (in_opcode == nsfp_pkg::OP_READ);
  assign b        = in_rx_byte;

  // field index after a comma, saturating at the last one
  always_comb begin
    if (field_idx_r == nsfp_pkg::NO_FIELD) begin
      idx_comma = 5'd0;
    end else if (field_idx_r < nsfp_pkg::LAST_FIELD) begin
      idx_comma = field_idx_r + 5'd1;
    end else begin
      idx_comma = field_idx_r;
    end
  end

  assign slot_cur   = nsfp_pkg::slot_of(kind_r, field_idx_r);
  assign slot_comma = nsfp_pkg::slot_of(kind_r, idx_comma);

  // satellites-in-view digits, saturated at 255
  assign is_digit = (b >= nsfp_pkg::CH_ZERO) && (b <= nsfp_pkg::CH_NINE);
  assign digit    = 4'(b - nsfp_pkg::CH_ZERO);
  assign acc_prod = {4'd0, view_acc_r} * 12'd10 + {8'd0, digit};

  // read path: length from the flop array, character from the memory
  always_comb begin
    rd_len = 4'd0;
    if (in_read_slot != nsfp_pkg::NO_SLOT) begin
      rd_len = len_r[in_read_slot];
    end
  end
  assign rd_char_ok = (in_read_pos < rd_len);

  // ---------------------------------------------------------------------------
  // Byte decoder
  // ---------------------------------------------------------------------------
  always_comb begin
    line_active_nxt = line_active_r;
    hdr_cnt_nxt     = hdr_cnt_r;
    hdr_nxt         = hdr_r;
    kind_nxt        = kind_r;
    field_idx_nxt   = field_idx_r;
    char_pos_nxt    = char_pos_r;
    len_nxt         = len_r;
    view_acc_nxt    = view_acc_r;
    digits_run_nxt  = digits_run_r;
    gps_nxt         = gps_r;
    glo_nxt         = glo_r;
    event_val       = nsfp_pkg::KIND_NONE;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_slot        = in_read_slot;
    mem_pos         = in_read_pos;

    if (accept && is_read) begin
      mem_re = rd_char_ok;
    end else if (accept) begin
      if (b == nsfp_pkg::CH_DOLLAR) begin
        // restart anywhere, even mid header or mid field
        line_active_nxt = 1'b1;
        hdr_cnt_nxt     = 3'd0;
        hdr_nxt         = 24'd0;
        kind_nxt        = nsfp_pkg::KIND_NONE;
        field_idx_nxt   = nsfp_pkg::NO_FIELD;
        char_pos_nxt    = 4'd0;
      end else if (line_active_r) begin
        if (hdr_cnt_r != nsfp_pkg::HDR_BODY) begin
          // talker letter, then four header letters; any byte counts
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          case (hdr_cnt_r)
            3'd1: hdr_nxt[7:0]   = b;
            3'd2: hdr_nxt[15:8]  = b;
            3'd3: hdr_nxt[23:16] = b;
            3'd4: begin
              kind_nxt = nsfp_pkg::classify({b, hdr_r});
              if (nsfp_pkg::classify({b, hdr_r}) == nsfp_pkg::KIND_NONE) begin
                line_active_nxt = 1'b0;
              end
            end
            default: hdr_nxt = hdr_r;
          endcase
        end else if (b == nsfp_pkg::CH_STAR) begin
          event_val       = kind_r;
          line_active_nxt = 1'b0;
          if (kind_r == nsfp_pkg::KIND_GPGSV) begin
            gps_nxt = view_acc_r;
          end else if (kind_r == nsfp_pkg::KIND_GLGSV) begin
            glo_nxt = view_acc_r;
          end
        end else if (b == nsfp_pkg::CH_COMMA) begin
          field_idx_nxt = idx_comma;
          char_pos_nxt  = 4'd0;
          if (slot_comma != nsfp_pkg::NO_SLOT) begin
            len_nxt[slot_comma] = 4'd0;
            if (slot_comma == nsfp_pkg::VIEW_SLOT) begin
              view_acc_nxt   = 8'd0;
              digits_run_nxt = 1'b1;
            end
          end
        end else if (field_idx_r != nsfp_pkg::NO_FIELD &&
                     slot_cur != nsfp_pkg::NO_SLOT &&
                     char_pos_r < 4'(MAX_STORED)) begin
          mem_we            = 1'b1;
          mem_slot          = slot_cur;
          mem_pos           = char_pos_r;
          char_pos_nxt      = char_pos_r + 4'd1;
          len_nxt[slot_cur] = char_pos_r + 4'd1;
          if (slot_cur == nsfp_pkg::VIEW_SLOT && digits_run_r) begin
            if (is_digit) begin
              view_acc_nxt = (acc_prod > 12'd255) ? 8'd255 : acc_prod[7:0];
            end else begin
              digits_run_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  // slot * FIELD_CHARS + position; only used in range
  assign mem_addr = AW'(mem_slot) * AW'(FIELD_CHARS) + AW'(mem_pos);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= b;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      hdr_cnt_r     <= 3'd0;
      kind_r        <= nsfp_pkg::KIND_NONE;
      field_idx_r   <= nsfp_pkg::NO_FIELD;
      char_pos_r    <= 4'd0;
      view_acc_r    <= 8'd0;
      digits_run_r  <= 1'b1;
      gps_r         <= 8'd0;
      glo_r         <= 8'd0;
      for (int i = 0; i < nsfp_pkg::NUM_SLOTS; i++) begin
        len_r[i] <= 4'd0;
      end
    end else begin
      line_active_r <= line_active_nxt;
      hdr_cnt_r     <= hdr_cnt_nxt;
      kind_r        <= kind_nxt;
      field_idx_r   <= field_idx_nxt;
      char_pos_r    <= char_pos_nxt;
      view_acc_r    <= view_acc_nxt;
      digits_run_r  <= digits_run_nxt;
      gps_r         <= gps_nxt;
      glo_r         <= glo_nxt;
      len_r         <= len_nxt;
    end
  end

  // header letters are payload, overwritten before use
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Read stage: holds while the buffer is full and no entry pops, mem_q_r holds
  // with it since no beat is accepted then.
  // ---------------------------------------------------------------------------
  assign push = s1_valid_r && (!buf_st.full || buf_st.pop);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_event_r   <= event_val;
      s1_len_r     <= is_read ? rd_len : 4'd0;
      s1_char_ok_r <= is_read && rd_char_ok;
      s1_gps_r     <= gps_nxt;
      s1_glo_r     <= glo_nxt;
    end
  end

  always_comb begin
    push_data.sentence_event = s1_event_r;
    push_data.read_char      = s1_char_ok_r ? mem_q_r : 8'd0;
    push_data.read_length    = s1_len_r;
    push_data.gps_sats       = s1_gps_r;
    push_data.glonass_sats   = s1_glo_r;
  end

  nsfp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .status    (buf_st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_sentence_event       = out_data.sentence_event;
  assign out_read_char            = out_data.read_char;
  assign out_read_length          = out_data.read_length;
  assign out_gps_sats_in_view     = out_data.gps_sats;
  assign out_glonass_sats_in_view = out_data.glonass_sats;

endmodule

`default_nettype wire

>>> sv/nsfp_checker.sv
// Port-level checks for the NMEA sentence field parser, bound to the top level.
`default_nettype none

module nsfp_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_stall,
  input wire [2:0] out_sentence_event,
  input wire [7:0] out_read_char,
  input wire [3:0] out_read_length,
  input wire [7:0] out_gps_sats_in_view,
  input wire [7:0] out_glonass_sats_in_view
);

  // no result beat straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sentence_event) &&
      $stable(out_read_char) && $stable(out_read_length) &&
      $stable(out_gps_sats_in_view) && $stable(out_glonass_sats_in_view))
    else $error("stalled result beat changed");

  // a completed sentence comes from a feed beat, which returns no slot data
  a_event_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_event != 3'd0 |->
      out_read_char == 8'd0 && out_read_length == 4'd0)
    else $error("sentence event carries read data");

  // a character is only returned below the stored length
  a_char_in_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_char != 8'd0 |-> out_read_length != 4'd0)
    else $error("character returned from an empty slot");

  // sentence codes above GLONASS GSV do not exist
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sentence_event != 3'd7)
    else $error("sentence event code out of range");

endmodule

bind nmea_sentence_field_parser nsfp_checker u_nsfp_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_sentence_event       (out_sentence_event),
  .out_read_char            (out_read_char),
  .out_read_length          (out_read_length),
  .out_gps_sats_in_view     (out_gps_sats_in_view),
  .out_glonass_sats_in_view (out_glonass_sats_in_view)
);

`default_nettype wire
